FILE: hdl/text_cell_pixel_shader_core_assert.svh
// Assertion macros shared by the text cell pixel shader checkers.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef TEXT_CELL_PIXEL_SHADER_CORE_ASSERT_SVH
`define TEXT_CELL_PIXEL_SHADER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TCPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TCPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tcps_pkg.sv
// Shared types, register codes and arithmetic helpers for the text cell pixel shader.
// No dependencies; used by the register file, the core and the checker.
package tcps_pkg;

  // Cell size limits
  localparam int MAX_GLYPH_WIDTH  = 32;
  localparam int MAX_GLYPH_HEIGHT = 64;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_GLYPH_WIDTH      = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_CURSOR_COLUMN    = 3'd2;
  localparam logic [2:0] REG_CURSOR_LINE      = 3'd3;
  localparam logic [2:0] REG_CURSOR_SHAPE     = 3'd4;
  localparam logic [2:0] REG_CURSOR_RGB       = 3'd5;
  localparam logic [2:0] REG_DISPLAY_FLAGS    = 3'd6;
  localparam logic [2:0] REG_SELECTION_COLORS = 3'd7;

  // Cursor shapes
  localparam logic [2:0] CUR_BLOCK     = 3'd1;
  localparam logic [2:0] CUR_HOLLOW    = 3'd2;
  localparam logic [2:0] CUR_UNDERLINE = 3'd3;
  localparam logic [2:0] CUR_BAR       = 3'd4;

  // Configuration register set
  typedef struct packed {
    logic [5:0]  glyph_width;
    logic [6:0]  glyph_height;
    logic [7:0]  cursor_column;
    logic [6:0]  cursor_line;
    logic [2:0]  cursor_shape;
    logic [23:0] cursor_rgb;
    logic [2:0]  display_flags;
    logic [49:0] selection_colors;
  } tcps_cfg_t;

  // x / 255 for x up to 65279 (quotient fits in 8 bits)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  // v / 6 for a 6-bit value, by reciprocal multiply (43 / 256)
  function automatic logic [3:0] div6(input logic [5:0] v);
    logic [11:0] p;
    p = {6'd0, v} * 12'd43;
    return p[11:8];
  endfunction

endpackage

FILE: hdl/tcps_regs.sv
// APB-style configuration register file for the text cell pixel shader.
// Depends on tcps_pkg for register codes and the tcps_cfg_t bundle.
module tcps_regs import tcps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output tcps_cfg_t   cfg
);

  localparam tcps_cfg_t CFG_RESET = '{
    glyph_width:      6'd8,
    glyph_height:     7'd16,
    cursor_column:    8'd0,
    cursor_line:      7'd0,
    cursor_shape:     CUR_BLOCK,
    cursor_rgb:       24'hFFFFFF,
    display_flags:    3'd2,
    selection_colors: 50'd0
  };

  tcps_cfg_t  cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GLYPH_WIDTH:      cfg_r.glyph_width      <= pwdata[5:0];
        REG_GLYPH_HEIGHT:     cfg_r.glyph_height     <= pwdata[6:0];
        REG_CURSOR_COLUMN:    cfg_r.cursor_column    <= pwdata[7:0];
        REG_CURSOR_LINE:      cfg_r.cursor_line      <= pwdata[6:0];
        REG_CURSOR_SHAPE:     cfg_r.cursor_shape     <= pwdata[2:0];
        REG_CURSOR_RGB:       cfg_r.cursor_rgb       <= pwdata[23:0];
        REG_DISPLAY_FLAGS:    cfg_r.display_flags    <= pwdata[2:0];
        REG_SELECTION_COLORS: cfg_r.selection_colors <= pwdata[49:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_GLYPH_WIDTH:      prdata = {58'd0, cfg_r.glyph_width};
      REG_GLYPH_HEIGHT:     prdata = {57'd0, cfg_r.glyph_height};
      REG_CURSOR_COLUMN:    prdata = {56'd0, cfg_r.cursor_column};
      REG_CURSOR_LINE:      prdata = {57'd0, cfg_r.cursor_line};
      REG_CURSOR_SHAPE:     prdata = {61'd0, cfg_r.cursor_shape};
      REG_CURSOR_RGB:       prdata = {40'd0, cfg_r.cursor_rgb};
      REG_DISPLAY_FLAGS:    prdata = {61'd0, cfg_r.display_flags};
      REG_SELECTION_COLORS: prdata = {14'd0, cfg_r.selection_colors};
      default:              prdata = 64'd0;
    endcase
  end

endmodule

FILE: hdl/text_cell_pixel_shader_core.sv
// Text cell pixel shader: one terminal cell pixel in, final color and screen position out.
// Depends on tcps_pkg and tcps_regs.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one pixel request: cell colors,
//   attributes, selection flag, cell and pixel position, coverage and color-glyph RGBA.
//   Output channel (out_valid / out_ready) returns pixel_rgb, screen_x, screen_y.
//   The APB port (psel .. pready, 64-bit data, registers at 8-byte spacing)
//   sets cell size, cursor, display flags and selection colors; write it only
//   while no request is in flight.
//   After the accepting edge the request passes through stages two to five, and
//   out_valid rises when it reaches the fifth; throughput is one pixel per cycle
//   while out_ready stays high, through five register stages (input capture,
//   color resolve, faint divide and cursor fill, channel multiplies, divide and overlay).
//   Each stage holds its request until the next stage frees up, so when the
//   receiver stalls the pipe fills up to five requests and then in_ready drops;
//   nothing is lost or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the register
//   defaults: 8x16 cells, filled white cursor at the top-left cell, blink phase visible.
module text_cell_pixel_shader_core import tcps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_fg_color,
  input  logic [23:0] in_bg_color,
  input  logic [23:0] in_underline_rgb,
  input  logic [10:0] in_attributes,
  input  logic        in_is_selected,
  input  logic [7:0]  in_cell_col,
  input  logic [6:0]  in_cell_row,
  input  logic [5:0]  in_px_x,
  input  logic [5:0]  in_px_y,
  input  logic [7:0]  in_coverage,
  input  logic [31:0] in_glyph_rgba,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_pixel_rgb,
  output logic [13:0] out_screen_x,
  output logic [12:0] out_screen_y,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Underline styles
  localparam logic [2:0] UL_NONE   = 3'd0;
  localparam logic [2:0] UL_SINGLE = 3'd1;
  localparam logic [2:0] UL_DOUBLE = 3'd2;
  localparam logic [2:0] UL_CURLY  = 3'd3;
  localparam logic [2:0] UL_DOTTED = 3'd4;
  localparam logic [2:0] UL_DASHED = 3'd5;

  // Fields that ride along to the decoration stage
  typedef struct packed {
    logic [23:0] ul;
    logic        strike;
    logic        over;
    logic        link;
    logic [2:0]  ustyle;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [5:0]  gw;
    logic [6:0]  ch;
    logic [6:0]  cw;
    logic [23:0] cur;
    logic        here;
    logic [13:0] sx;
    logic [12:0] sy;
  } deco_t;

  tcps_cfg_t cfg;

  tcps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its content moves on
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input capture
  logic [23:0] s1_fg_r, s1_bg_r, s1_ul_r;
  logic [10:0] s1_attr_r;
  logic        s1_sel_r;
  logic [7:0]  s1_col_r;
  logic [6:0]  s1_row_r;
  logic [5:0]  s1_x_r, s1_y_r;
  logic [7:0]  s1_cov_r;
  logic [31:0] s1_rgba_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_fg_r   <= in_fg_color;
      s1_bg_r   <= in_bg_color;
      s1_ul_r   <= in_underline_rgb;
      s1_attr_r <= in_attributes;
      s1_sel_r  <= in_is_selected;
      s1_col_r  <= in_cell_col;
      s1_row_r  <= in_cell_row;
      s1_x_r    <= in_px_x;
      s1_y_r    <= in_px_y;
      s1_cov_r  <= in_coverage;
      s1_rgba_r <= in_glyph_rgba;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cell size, color swaps, cursor match, faint products, positions
  logic [5:0]  gw_nxt;
  logic [6:0]  gh_nxt;
  logic [23:0] fg_sw, bg_sw, s2_fg_nxt, s2_bg_nxt, s2_cur_nxt;
  logic [1:0]  sel_mask;
  logic [15:0] s2_fsum_nxt [3];
  logic        s2_hidden_nxt;
  logic [13:0] sx_prod;
  logic [12:0] sy_prod;
  deco_t       s2_deco_nxt;

  always_comb begin
    // clamp the cell size
    if (cfg.glyph_width == 6'd0) begin
      gw_nxt = 6'd1;
    end else if (cfg.glyph_width > 6'(MAX_GLYPH_WIDTH)) begin
      gw_nxt = 6'(MAX_GLYPH_WIDTH);
    end else begin
      gw_nxt = cfg.glyph_width;
    end
    if (cfg.glyph_height == 7'd0) begin
      gh_nxt = 7'd1;
    end else if (cfg.glyph_height > 7'(MAX_GLYPH_HEIGHT)) begin
      gh_nxt = 7'(MAX_GLYPH_HEIGHT);
    end else begin
      gh_nxt = cfg.glyph_height;
    end

    // inverse against screen reverse
    if (s1_attr_r[1] != cfg.display_flags[0]) begin
      fg_sw = s1_bg_r;
      bg_sw = s1_fg_r;
    end else begin
      fg_sw = s1_fg_r;
      bg_sw = s1_bg_r;
    end

    // selection: swap, or override the masked colors
    sel_mask  = cfg.selection_colors[49:48];
    s2_fg_nxt = fg_sw;
    s2_bg_nxt = bg_sw;
    if (s1_sel_r) begin
      if (sel_mask == 2'd0) begin
        s2_fg_nxt = bg_sw;
        s2_bg_nxt = fg_sw;
      end else begin
        if (sel_mask[0]) s2_fg_nxt = cfg.selection_colors[47:24];
        if (sel_mask[1]) s2_bg_nxt = cfg.selection_colors[23:0];
      end
    end

    // faint half blend numerators: f*128 + b*127 + 127
    for (int i = 0; i < 3; i++) begin
      s2_fsum_nxt[i] = {1'b0, s2_fg_nxt[i*8 +: 8], 7'd0}
                     + ({8'd0, s2_bg_nxt[i*8 +: 8]} * 16'd127) + 16'd127;
    end

    s2_hidden_nxt = s1_attr_r[3] || (s1_attr_r[4] && !cfg.display_flags[1]);

    // cursor color, inverted when it matches the background
    s2_cur_nxt = (cfg.cursor_rgb == s2_bg_nxt) ? ~cfg.cursor_rgb : cfg.cursor_rgb;

    sx_prod = {6'd0, s1_col_r} * {8'd0, gw_nxt};
    sy_prod = {6'd0, s1_row_r} * {6'd0, gh_nxt};

    s2_deco_nxt.ul     = s1_ul_r;
    s2_deco_nxt.strike = s1_attr_r[5];
    s2_deco_nxt.over   = s1_attr_r[6];
    s2_deco_nxt.link   = s1_attr_r[7];
    s2_deco_nxt.ustyle = s1_attr_r[10:8];
    s2_deco_nxt.x      = s1_x_r;
    s2_deco_nxt.y      = s1_y_r;
    s2_deco_nxt.gw     = gw_nxt;
    s2_deco_nxt.ch     = gh_nxt;
    s2_deco_nxt.cw     = s1_attr_r[0] ? {gw_nxt, 1'b0} : {1'b0, gw_nxt};
    s2_deco_nxt.cur    = s2_cur_nxt;
    s2_deco_nxt.here   = (s1_col_r == cfg.cursor_column) && (s1_row_r == cfg.cursor_line)
                      && (!cfg.display_flags[2] || cfg.display_flags[1]);
    s2_deco_nxt.sx     = sx_prod + {8'd0, s1_x_r};
    s2_deco_nxt.sy     = sy_prod + {7'd0, s1_y_r};
  end

  logic [23:0] s2_fg_r, s2_bg_r;
  logic [15:0] s2_fsum_r [3];
  logic        s2_faint_r, s2_hidden_r;
  logic [7:0]  s2_cov_r;
  logic [31:0] s2_rgba_r;
  deco_t       s2_deco_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_fg_r     <= s2_fg_nxt;
      s2_bg_r     <= s2_bg_nxt;
      s2_fsum_r   <= s2_fsum_nxt;
      s2_faint_r  <= s1_attr_r[2];
      s2_hidden_r <= s2_hidden_nxt;
      s2_cov_r    <= s1_cov_r;
      s2_rgba_r   <= s1_rgba_r;
      s2_deco_r   <= s2_deco_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: faint divide, hiding, filled cursor, scaled glyph alpha
  logic [23:0] s3_fg_nxt, s3_bg_nxt, fg_faint;
  logic [7:0]  s3_alpha_nxt;

  always_comb begin
    fg_faint = {div255(s2_fsum_r[2]), div255(s2_fsum_r[1]), div255(s2_fsum_r[0])};
    s3_fg_nxt = s2_faint_r ? fg_faint : s2_fg_r;
    s3_bg_nxt = s2_bg_r;
    if (s2_hidden_r) s3_fg_nxt = s2_bg_r;
    if (s2_deco_r.here && cfg.cursor_shape == CUR_BLOCK) begin
      s3_fg_nxt = s2_bg_r;
      s3_bg_nxt = s2_deco_r.cur;
    end
    s3_alpha_nxt = s2_faint_r ? div255({1'b0, s2_rgba_r[7:0], 7'd0}) : s2_rgba_r[7:0];
  end

  logic [23:0] s3_fg_r, s3_bg_r, s3_grgb_r;
  logic [7:0]  s3_alpha_r, s3_cov_r;
  logic        s3_glyph_r, s3_faint_r;
  deco_t       s3_deco_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_fg_r    <= s3_fg_nxt;
      s3_bg_r    <= s3_bg_nxt;
      s3_grgb_r  <= s2_rgba_r[31:8];
      s3_alpha_r <= s3_alpha_nxt;
      s3_cov_r   <= s2_cov_r;
      s3_glyph_r <= !s2_hidden_r && (s2_rgba_r[7:0] != 8'd0);
      s3_faint_r <= s2_faint_r;
      s3_deco_r  <= s2_deco_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: channel products (blend or glyph) and decoration decision
  logic [15:0] s4_p1_nxt [3];
  logic [15:0] s4_p2_nxt [3];
  logic [7:0]  m1a, m1b, m2a, m2b;
  deco_t       d;
  logic        px_in_cell, hyper, draw, pat, wave, ul_hit, strike_hit, over_hit, cur_hit;
  logic [2:0]  st;
  logic [23:0] uc;
  logic [3:0]  x_q, th_u, th_b;
  logic [5:0]  x_r;
  logic        s4_ovr_nxt;
  logic [23:0] s4_ovr_rgb_nxt;

  always_comb begin
    // shared multipliers: f*c and b*(255-c), or C*s and b*(255-a')
    for (int i = 0; i < 3; i++) begin
      if (s3_glyph_r) begin
        m1a = s3_grgb_r[i*8 +: 8];
        m1b = s3_faint_r ? 8'd128 : 8'd255;
        m2b = 8'd255 - s3_alpha_r;
      end else begin
        m1a = s3_fg_r[i*8 +: 8];
        m1b = s3_cov_r;
        m2b = 8'd255 - s3_cov_r;
      end
      m2a = s3_bg_r[i*8 +: 8];
      s4_p1_nxt[i] = {8'd0, m1a} * {8'd0, m1b};
      s4_p2_nxt[i] = {8'd0, m2a} * {8'd0, m2b};
    end

    d          = s3_deco_r;
    px_in_cell = ({1'b0, d.x} < d.cw) && ({1'b0, d.y} < d.ch);

    // underline / hyperlink underline
    hyper = (d.ustyle == UL_NONE) && d.link;
    st    = hyper ? UL_SINGLE : d.ustyle;
    uc    = hyper ? s3_fg_r : d.ul;
    x_q   = div6(d.x);
    x_r   = d.x - {x_q, 2'b00} - {1'b0, x_q, 1'b0};
    draw  = (st != UL_DOTTED) || !d.x[0];
    pat   = (st != UL_DASHED) || (x_r < 6'd4);
    wave  = (st == UL_CURLY) && d.x[0];
    ul_hit = ((d.ustyle != UL_NONE) || hyper)
          && ((draw && pat && (({2'b0, d.y} + 8'd1 + {7'd0, wave}) == {1'b0, d.ch}))
           || ((st == UL_DOUBLE) && (d.ch > 7'd2) && (({2'b0, d.y} + 8'd3) == {1'b0, d.ch})));

    strike_hit = d.strike && (d.y == d.ch[6:1]);
    over_hit   = d.over && (d.y == 6'd0);

    // cursor outlines
    th_u = (d.ch[6:3] == 4'd0) ? 4'd1 : d.ch[6:3];
    th_b = (div6(d.gw) == 4'd0) ? 4'd1 : div6(d.gw);
    case (cfg.cursor_shape)
      CUR_HOLLOW:    cur_hit = (d.y == 6'd0) || (({1'b0, d.y} + 7'd1) == d.ch)
                            || (d.x == 6'd0) || (({1'b0, d.x} + 7'd1) == d.cw);
      CUR_UNDERLINE: cur_hit = ({2'b0, d.y} + {4'd0, th_u}) >= {1'b0, d.ch};
      CUR_BAR:       cur_hit = d.x < {2'b0, th_b};
      default:       cur_hit = 1'b0;
    endcase
    cur_hit = cur_hit && d.here;

    // the cursor wins over overline/strike, which win over underline
    s4_ovr_nxt     = 1'b0;
    s4_ovr_rgb_nxt = uc;
    if (px_in_cell) begin
      if (cur_hit) begin
        s4_ovr_nxt     = 1'b1;
        s4_ovr_rgb_nxt = d.cur;
      end else if (over_hit || strike_hit) begin
        s4_ovr_nxt     = 1'b1;
        s4_ovr_rgb_nxt = s3_fg_r;
      end else if (ul_hit) begin
        s4_ovr_nxt     = 1'b1;
        s4_ovr_rgb_nxt = uc;
      end
    end
  end

  logic [15:0] s4_p1_r [3];
  logic [15:0] s4_p2_r [3];
  logic        s4_glyph_r, s4_ovr_r;
  logic [23:0] s4_ovr_rgb_r;
  logic [13:0] s4_sx_r;
  logic [12:0] s4_sy_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_p1_r      <= s4_p1_nxt;
      s4_p2_r      <= s4_p2_nxt;
      s4_glyph_r   <= s3_glyph_r;
      s4_ovr_r     <= s4_ovr_nxt;
      s4_ovr_rgb_r <= s4_ovr_rgb_nxt;
      s4_sx_r      <= s3_deco_r.sx;
      s4_sy_r      <= s3_deco_r.sy;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: divide by 255, saturate glyph channels, apply overlay
  logic [23:0] base_rgb, s5_pix_nxt;
  logic [8:0]  gsum;
  logic [15:0] bsum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gsum = {1'b0, div255(s4_p1_r[i])} + {1'b0, div255(s4_p2_r[i])};
      bsum = s4_p1_r[i] + s4_p2_r[i] + 16'd127;
      if (s4_glyph_r) begin
        base_rgb[i*8 +: 8] = gsum[8] ? 8'd255 : gsum[7:0];
      end else begin
        base_rgb[i*8 +: 8] = div255(bsum);
      end
    end
    s5_pix_nxt = s4_ovr_r ? s4_ovr_rgb_r : base_rgb;
  end

  logic [23:0] s5_pix_r;
  logic [13:0] s5_sx_r;
  logic [12:0] s5_sy_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_pix_r <= s5_pix_nxt;
      s5_sx_r  <= s4_sx_r;
      s5_sy_r  <= s4_sy_r;
    end
  end

  assign out_pixel_rgb = s5_pix_r;
  assign out_screen_x  = s5_sx_r;
  assign out_screen_y  = s5_sy_r;

endmodule

FILE: hdl/tcps_checker.sv
// Port-level checker for the text cell pixel shader, bound to the top level.
// Depends on tcps_pkg and text_cell_pixel_shader_core_assert.svh.
`include "text_cell_pixel_shader_core_assert.svh"

module tcps_checker import tcps_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [23:0] in_fg_color,
  input logic [23:0] in_bg_color,
  input logic [23:0] in_underline_rgb,
  input logic [10:0] in_attributes,
  input logic        in_is_selected,
  input logic [7:0]  in_cell_col,
  input logic [6:0]  in_cell_row,
  input logic [5:0]  in_px_x,
  input logic [5:0]  in_px_y,
  input logic [7:0]  in_coverage,
  input logic [31:0] in_glyph_rgba,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_pixel_rgb,
  input logic [13:0] out_screen_x,
  input logic [12:0] out_screen_y,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [5:0]  paddr,
  input logic [63:0] pwdata,
  input logic [63:0] prdata,
  input logic        pready
);

  // stalled result holds
  `TCPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_rgb) && $stable(out_screen_x) && $stable(out_screen_y), "result changed while stalled")

  // a draining output never blocks the input
  `TCPS_ASSERT_IMP(a_drain_frees_input, out_ready, in_ready, "input blocked while output drains")

  // result reaches the output when the receiver keeps up
  `TCPS_ASSERT_NXT(a_latency, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "result missing after pipeline latency")

  // cursor color reads back what was written
  `TCPS_ASSERT_IMP(a_rgb_readback, (psel && penable && pwrite && pready && paddr[5:3] == REG_CURSOR_RGB) ##1 (paddr[5:3] == REG_CURSOR_RGB), prdata[23:0] == $past(pwdata[23:0]), "cursor color readback mismatch")

endmodule

bind text_cell_pixel_shader_core tcps_checker u_tcps_checker (.*);
